FILE: hdl/psa_pkg.sv
// Shared types, constants and helper functions of the segregated split allocator.
package psa_pkg;

  localparam int POOL_COUNT   = 16;
  localparam int HEADER_BYTES = 16;
  localparam int TOP_BLOCKS   = 8;
  localparam int MIN_CLASS    = 4;

  localparam int TOP_CLASS     = POOL_COUNT - 1;
  localparam int TOP_SHIFT     = TOP_CLASS - MIN_CLASS;
  localparam int ARENA_GRANULES = TOP_BLOCKS << TOP_SHIFT;
  localparam int GRAN_W        = $clog2(ARENA_GRANULES);
  localparam int CLASS_W       = $clog2(POOL_COUNT);
  localparam int FRESH_W       = $clog2(TOP_BLOCKS + 1);
  localparam int SIZE_W        = 20;
  localparam int ADDR_W        = 18;
  localparam int BYTES_W       = SIZE_W + 1;
  localparam int CFULL_W       = $clog2(BYTES_W + 1);
  localparam int LIMIT_W       = 4;
  localparam int STATUS_W      = 2;
  localparam int OCLS_W        = 4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] user_address;
  } psa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
    logic [OCLS_W-1:0]   size_class;
  } psa_rsp_t;

  typedef struct packed {
    logic               en;
    logic               valid;
    logic [CLASS_W-1:0] cls;
    logic [GRAN_W-1:0]  head;
  } psa_head_wr_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_POP, S_POP_DATA, S_SPLIT,
    S_ALLOC_DONE, S_FREE_RD, S_FREE_CHK, S_RESP
  } psa_state_t;

  function automatic logic [CFULL_W-1:0] class_of(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W-1:0] v;
    logic [CFULL_W-1:0] c;
    v = bytes - BYTES_W'(1);
    c = '0;
    for (int i = 0; i < BYTES_W; i++) begin
      if (v[i]) c = CFULL_W'(i + 1);
    end
    if (c < CFULL_W'(MIN_CLASS)) c = CFULL_W'(MIN_CLASS);
    return c;
  endfunction

  function automatic logic [OCLS_W-1:0] sat_class(input logic [CFULL_W-1:0] c);
    return (c > CFULL_W'(15)) ? OCLS_W'(15) : OCLS_W'(c);
  endfunction

endpackage

FILE: hdl/psa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hdl/psa_heads.sv
// Free-list head table: one head granule and valid bit per size class.
module psa_heads
  import psa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [CLASS_W-1:0] rd_cls,
  output logic               rd_valid,
  output logic [GRAN_W-1:0]  rd_head,
  input  psa_head_wr_t       wr
);
  logic [POOL_COUNT-1:0] valid;
  logic [GRAN_W-1:0]     head [POOL_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.cls] <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) head[wr.cls] <= wr.head;
  end

  assign rd_valid = valid[rd_cls];
  assign rd_head  = head[rd_cls];
endmodule

FILE: hdl/pow2_segregated_split_allocator_core.sv
// Top level of the power-of-two segregated free-list allocator with split-down.
//
// Channel  Signals                       Direction  Contents
// req      req_valid, req_ready, req     in         allocate or free request
// rsp      rsp_valid, rsp_ready, rsp     out        address, status, class
// cfg      cfg_we, cfg_data              in         top block limit
//
// After reset a clearing pass sweeps the class/mark memory; no request is taken
// until it ends. A free reads and checks the mark; a too-large allocate or a
// null or bad free goes straight to the response. An allocate searches classes
// upward, pops a list if one is found, splits down level by level; the single
// head-table port and registered memory reads set the pace. A stalled response
// holds the engine in its response state until the output register is free.
module pow2_segregated_split_allocator_core
  import psa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  psa_req_t           req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output psa_rsp_t           rsp
);
  psa_state_t state, state_next;

  logic [CLASS_W-1:0]  k;
  logic [CLASS_W-1:0]  c;
  logic [GRAN_W-1:0]   g;
  logic [GRAN_W-1:0]   clr;
  logic [FRESH_W-1:0]  fresh;
  logic [LIMIT_W-1:0]  limit;
  psa_rsp_t            res;

  logic [CLASS_W-1:0]  rd_cls;
  logic                hd_valid;
  logic [GRAN_W-1:0]   hd_head;
  psa_head_wr_t        hd_wr;

  logic                lk_we;
  logic [GRAN_W-1:0]   lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic                cm_we;
  logic [GRAN_W-1:0]   cm_waddr, cm_raddr;
  logic [CLASS_W:0]    cm_wdata, cm_rdata;

  logic [CFULL_W-1:0]  in_cls;
  logic [ADDR_W-1:0]   in_base;
  logic                in_good;
  logic                fresh_ok;
  logic [CLASS_W-1:0]  kk;
  logic [GRAN_W-1:0]   up;

  assign in_cls   = class_of(BYTES_W'(req.request_size) + BYTES_W'(HEADER_BYTES));
  assign in_base  = req.user_address - ADDR_W'(HEADER_BYTES);
  assign in_good  = (req.user_address >= ADDR_W'(HEADER_BYTES))
                 && (in_base[MIN_CLASS-1:0] == '0)
                 && ((in_base >> MIN_CLASS) < ADDR_W'(ARENA_GRANULES));
  assign fresh_ok = (fresh < FRESH_W'(limit)) && (fresh < FRESH_W'(TOP_BLOCKS));
  assign kk       = k - CLASS_W'(1);
  assign up       = g + (GRAN_W'(1) << (kk - CLASS_W'(MIN_CLASS)));
  assign req_ready = (state == S_IDLE);

  psa_heads u_heads (
    .clk(clk), .rst(rst), .rd_cls(rd_cls), .rd_valid(hd_valid), .rd_head(hd_head),
    .wr(hd_wr)
  );

  psa_ram #(.WIDTH(GRAN_W), .DEPTH(ARENA_GRANULES)) u_link (
    .clk(clk), .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
    .rd_addr(lk_raddr), .rd_data(lk_rdata)
  );

  psa_ram #(.WIDTH(CLASS_W + 1), .DEPTH(ARENA_GRANULES)) u_class (
    .clk(clk), .wr_en(cm_we), .wr_addr(cm_waddr), .wr_data(cm_wdata),
    .rd_addr(cm_raddr), .rd_data(cm_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:      if (clr == GRAN_W'(ARENA_GRANULES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) begin
          if (req.kind == KIND_ALLOC) begin
            state_next = (in_cls >= CFULL_W'(POOL_COUNT)) ? S_RESP : S_SEARCH;
          end else begin
            state_next = (req.user_address != '0 && in_good) ? S_FREE_RD : S_RESP;
          end
        end
      end
      S_SEARCH: begin
        if (hd_valid) state_next = S_POP;
        else if (k == CLASS_W'(TOP_CLASS)) state_next = fresh_ok ? S_SPLIT : S_RESP;
      end
      S_POP:        state_next = S_POP_DATA;
      S_POP_DATA:   state_next = S_SPLIT;
      S_SPLIT:      if (k == c) state_next = S_ALLOC_DONE;
      S_ALLOC_DONE: state_next = S_RESP;
      S_FREE_RD:    state_next = S_FREE_CHK;
      S_FREE_CHK:   state_next = S_RESP;
      S_RESP:       if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_cls   = k;
    hd_wr    = '0;
    lk_we    = 1'b0;
    lk_waddr = g;
    lk_wdata = g;
    lk_raddr = hd_head;
    cm_we    = 1'b0;
    cm_waddr = g;
    cm_wdata = '0;
    cm_raddr = g;
    unique case (state)
      S_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr;
      end
      S_POP_DATA: begin
        hd_wr.en    = 1'b1;
        hd_wr.cls   = k;
        hd_wr.valid = (lk_rdata != g);
        hd_wr.head  = lk_rdata;
      end
      S_SPLIT: begin
        rd_cls = kk;
        if (k != c) begin
          lk_we       = 1'b1;
          lk_waddr    = up;
          lk_wdata    = hd_valid ? hd_head : up;
          cm_we       = 1'b1;
          cm_waddr    = up;
          cm_wdata    = {1'b0, kk};
          hd_wr.en    = 1'b1;
          hd_wr.valid = 1'b1;
          hd_wr.cls   = kk;
          hd_wr.head  = up;
        end
      end
      S_ALLOC_DONE: begin
        cm_we    = 1'b1;
        cm_wdata = {1'b1, c};
      end
      S_FREE_CHK: begin
        rd_cls = cm_rdata[CLASS_W-1:0];
        if (cm_rdata[CLASS_W]) begin
          cm_we       = 1'b1;
          cm_wdata    = {1'b0, cm_rdata[CLASS_W-1:0]};
          lk_we       = 1'b1;
          lk_wdata    = hd_valid ? hd_head : g;
          hd_wr.en    = 1'b1;
          hd_wr.valid = 1'b1;
          hd_wr.cls   = cm_rdata[CLASS_W-1:0];
          hd_wr.head  = g;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      fresh     <= '0;
      limit     <= LIMIT_W'(8);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) limit <= cfg_data;
      if (state == S_CLEAR) clr <= clr + GRAN_W'(1);
      if (state == S_SEARCH && !hd_valid && k == CLASS_W'(TOP_CLASS) && fresh_ok) begin
        fresh <= fresh + FRESH_W'(1);
      end
      if (state == S_RESP && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        k <= CLASS_W'(in_cls);
        c <= CLASS_W'(in_cls);
        g <= GRAN_W'(in_base >> MIN_CLASS);
        res.result_address <= '0;
        res.size_class     <= '0;
        res.status         <= ST_OK;
        if (req.kind == KIND_ALLOC) begin
          res.size_class <= sat_class(in_cls);
          res.status     <= ST_TOO_LARGE;
        end else if (req.user_address != '0 && !in_good) begin
          res.status <= ST_BAD_FREE;
        end
      end
      S_SEARCH: begin
        if (!hd_valid) begin
          if (k == CLASS_W'(TOP_CLASS)) begin
            g          <= GRAN_W'(fresh) << TOP_SHIFT;
            res.status <= ST_OOM;
          end else begin
            k <= k + CLASS_W'(1);
          end
        end
      end
      S_POP:   g <= hd_head;
      S_SPLIT: if (k != c) k <= kk;
      S_ALLOC_DONE: begin
        res.result_address <= ADDR_W'({g, {MIN_CLASS{1'b0}}}) + ADDR_W'(HEADER_BYTES);
        res.status         <= ST_OK;
      end
      S_FREE_CHK: begin
        if (cm_rdata[CLASS_W]) begin
          res.status     <= ST_OK;
          res.size_class <= OCLS_W'(cm_rdata[CLASS_W-1:0]);
        end else begin
          res.status <= ST_BAD_FREE;
        end
      end
      default: begin
      end
    endcase
    if (state == S_RESP && (!rsp_valid || rsp_ready)) rsp <= res;
  end

`ifndef SYNTHESIS
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= FRESH_W'(TOP_BLOCKS)) else $error("fresh block count past arena size");
  a_split_floor: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> k >= c) else $error("split went below requested class");
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_RESP) else $error("response outside resp state");
  a_null_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && req.kind == KIND_FREE && req.user_address == '0)
    |=> state == S_RESP) else $error("null free did not answer at once");
`endif
endmodule
